// ----- design/sorted_alarm_queue_core_defines.svh -----
// Assertion macros shared by the queue modules.
`ifndef SORTED_ALARM_QUEUE_CORE_DEFINES_SVH
`define SORTED_ALARM_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/saq_pkg.sv -----
package saq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  localparam int DAY_W   = 16;
  localparam int MIN_W   = 11;
  localparam int MS_W    = 16;
  localparam int MSG_W   = 16;
  localparam int KIND_W  = 2;
  localparam int TAG_W   = 8;
  localparam int VOICE_W = 16;
  localparam int IDX_W   = 8;
  localparam int LEFT_W  = 5;
  localparam int KEY_W   = DAY_W + MIN_W + MS_W;
  localparam int PAY_W   = MSG_W + KIND_W + TAG_W + VOICE_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_FULL   = 3'd1,
    ST_BADIDX = 3'd2,
    ST_FIRED  = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic do_op;
    logic pop;
    logic none;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_due;
    logic next_due;
  } sts_t;

endpackage

// ----- design/saq_ctrl.sv -----
`include "sorted_alarm_queue_core_defines.svh"

module saq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_opcode,
  input  saq_pkg::sts_t sts,
  output saq_pkg::cmd_t cmd,
  output logic          busy
);
  import saq_pkg::*;

  localparam int PCW = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_TICK
  } state_t;

  state_t         state_r, state_nxt;
  logic           busy_r, busy_nxt;
  logic [PCW-1:0] pop_cnt_r, pop_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    busy_nxt    = busy_r;
    pop_cnt_nxt = pop_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          busy_nxt    = 1'b1;
          pop_cnt_nxt = '0;
          state_nxt   = (op_t'(in_opcode) == OP_TICK) ? S_TICK : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.do_op = 1'b1;
        cmd.last  = 1'b1;
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        // The head can only be not due on the first beat of a tick.
        if (sts.head_due) begin
          cmd.pop     = 1'b1;
          cmd.last    = !sts.next_due || (pop_cnt_r == PCW'(MAX_RESULTS - 1));
          pop_cnt_nxt = pop_cnt_r + PCW'(1);
        end else begin
          cmd.none = 1'b1;
          cmd.last = 1'b1;
        end
        if (cmd.last) begin
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      busy_r    <= 1'b0;
      pop_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      busy_r    <= busy_nxt;
      pop_cnt_r <= pop_cnt_nxt;
    end
  end

  assign busy = busy_r;

  `SAQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy_r, busy_r, "accept did not raise busy")
  `SAQ_ASSERT_NXT(a_last_frees, clk, rst_n, cmd.last, !busy_r && state_r == S_IDLE, "last beat did not free block")
  `SAQ_ASSERT_IMP(a_busy_state, clk, rst_n, busy_r, state_r != S_IDLE, "busy while idle")

endmodule

// ----- design/saq_datapath.sv -----
`include "sorted_alarm_queue_core_defines.svh"

module saq_datapath #(
  parameter int DEPTH = saq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  saq_pkg::cmd_t                     cmd,
  output saq_pkg::sts_t                     sts,
  input  logic [1:0]                        in_opcode,
  input  logic [saq_pkg::DAY_W-1:0]         in_event_day,
  input  logic [saq_pkg::MIN_W-1:0]         in_event_minute,
  input  logic [saq_pkg::MS_W-1:0]          in_event_ms,
  input  logic [saq_pkg::MSG_W-1:0]         in_message_id,
  input  logic [saq_pkg::KIND_W-1:0]        in_tag_kind,
  input  logic [saq_pkg::TAG_W-1:0]         in_tag_id,
  input  logic signed [saq_pkg::VOICE_W-1:0] in_voice_value,
  input  logic [saq_pkg::IDX_W-1:0]         in_entry_index,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [saq_pkg::MSG_W-1:0]         out_fired_message,
  output logic [saq_pkg::KIND_W-1:0]        out_fired_tag_kind,
  output logic [saq_pkg::TAG_W-1:0]         out_fired_tag_id,
  output logic signed [saq_pkg::VOICE_W-1:0] out_fired_voice_value,
  output logic [saq_pkg::DAY_W-1:0]         out_fired_day,
  output logic [saq_pkg::MIN_W-1:0]         out_fired_minute,
  output logic [saq_pkg::LEFT_W-1:0]        out_entries_left,
  output logic                              out_last
);
  import saq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > IDX_W) ? CW : IDX_W;

  // Latched command beat.
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] new_pay_r;
  logic [IDX_W-1:0] idx_r;

  // Sorted row of entries; entry 0 is the earliest.
  logic [KEY_W-1:0] due_r   [DEPTH];
  logic [KEY_W-1:0] due_nxt [DEPTH];
  logic [PAY_W-1:0] pld_r   [DEPTH];
  logic [PAY_W-1:0] pld_nxt [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [PAY_W-1:0] fired_pay_r, fired_pay_nxt;
  logic [DAY_W-1:0] fired_day_r, fired_day_nxt;
  logic [MIN_W-1:0] fired_min_r, fired_min_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             last_r;

  logic [DEPTH-1:0] le;
  logic             full;
  logic             idx_ok;

  function automatic logic due_hit(input logic [KEY_W-1:0] k, input logic [KEY_W-1:0] now);
    due_hit = (k[KEY_W-DAY_W-1:MS_W] == now[KEY_W-DAY_W-1:MS_W]) || (k < now);
  endfunction

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count_r) && (due_r[i] <= key_r);
    end
  end

  assign full   = (count_r == CW'(DEPTH));
  assign idx_ok = (IW'(idx_r) < IW'(count_r));

  assign sts.head_due = (count_r != '0) && due_hit(due_r[0], key_r);
  assign sts.next_due = (count_r > CW'(1)) && due_hit(due_r[1], key_r);

  always_comb begin
    due_nxt   = due_r;
    pld_nxt   = pld_r;
    count_nxt = count_r;
    if (cmd.do_op) begin
      unique case (op_r)
        OP_ADD: begin
          if (!full) begin
            // An entry moves up by one when it is later than the new key.
            if (!le[0]) begin
              due_nxt[0] = key_r;
              pld_nxt[0] = new_pay_r;
            end
            for (int i = 1; i < DEPTH; i++) begin
              if (!le[i-1]) begin
                due_nxt[i] = due_r[i-1];
                pld_nxt[i] = pld_r[i-1];
              end else if (!le[i]) begin
                due_nxt[i] = key_r;
                pld_nxt[i] = new_pay_r;
              end
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (idx_ok) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (IW'(i) >= IW'(idx_r)) begin
                due_nxt[i] = due_r[i+1];
                pld_nxt[i] = pld_r[i+1];
              end
            end
            count_nxt = count_r - CW'(1);
          end
        end
        OP_CLEAR: count_nxt = '0;
        OP_TICK:  count_nxt = count_r;
      endcase
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        due_nxt[i] = due_r[i+1];
        pld_nxt[i] = pld_r[i+1];
      end
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    status_nxt    = ST_DONE;
    fired_pay_nxt = '0;
    fired_day_nxt = '0;
    fired_min_nxt = '0;
    if (cmd.do_op) begin
      unique case (op_r)
        OP_ADD:    status_nxt = full ? ST_FULL : ST_DONE;
        OP_REMOVE: status_nxt = idx_ok ? ST_DONE : ST_BADIDX;
        OP_CLEAR:  status_nxt = ST_DONE;
        OP_TICK:   status_nxt = ST_DONE;
      endcase
    end else if (cmd.pop) begin
      status_nxt    = ST_FIRED;
      fired_pay_nxt = pld_r[0];
      fired_day_nxt = due_r[0][KEY_W-1:KEY_W-DAY_W];
      fired_min_nxt = due_r[0][KEY_W-DAY_W-1:MS_W];
    end else if (cmd.none) begin
      status_nxt = ST_NONE;
    end
    left_nxt = (count_nxt > CW'(31)) ? CW'(31) : count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_t'(in_opcode);
      key_r     <= {in_event_day, in_event_minute, in_event_ms};
      new_pay_r <= {in_message_id, in_tag_kind, in_tag_id, in_voice_value};
      idx_r     <= in_entry_index;
    end
    due_r       <= due_nxt;
    pld_r       <= pld_nxt;
    status_r    <= status_nxt;
    fired_pay_r <= fired_pay_nxt;
    fired_day_r <= fired_day_nxt;
    fired_min_r <= fired_min_nxt;
    left_r      <= left_nxt;
    last_r      <= cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.do_op || cmd.pop || cmd.none;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_fired_message     = fired_pay_r[PAY_W-1:PAY_W-MSG_W];
  assign out_fired_tag_kind    = fired_pay_r[VOICE_W+TAG_W+KIND_W-1:VOICE_W+TAG_W];
  assign out_fired_tag_id      = fired_pay_r[VOICE_W+TAG_W-1:VOICE_W];
  assign out_fired_voice_value = $signed(fired_pay_r[VOICE_W-1:0]);
  assign out_fired_day         = fired_day_r;
  assign out_fired_minute      = fired_min_r;
  assign out_entries_left      = LEFT_W'(left_r);
  assign out_last              = last_r;

  `SAQ_ASSERT_IMP(a_pop_due, clk, rst_n, cmd.pop, sts.head_due && count_r != '0, "pop of an entry not due")
  `SAQ_ASSERT_NXT(a_pop_count, clk, rst_n, cmd.pop, count_r == $past(count_r) - CW'(1), "pop did not shrink count")
  `SAQ_ASSERT_IMP(a_count_max, clk, rst_n, out_valid_r, count_r <= CW'(DEPTH), "count beyond depth")

endmodule

// ----- design/sorted_alarm_queue_core.sv -----
// Sorted alarm queue: keeps up to DEPTH alarms ordered by due time
// (day, minute, millisecond); equal times keep the order they were added in.
// Input channel: a command beat is taken at a rising edge with start high and
// busy low. Opcodes are add, remove at index, clear and tick.
// Result channel: out_valid marks each result beat for one cycle; the receiver
// cannot stall it, and out_last flags the final beat of a command.
// The command beat is registered, then the controller issues the update, and
// each result is registered before it is shown. Add, remove and clear give one
// result. A tick that fires k entries (k at most MAX_RESULTS) gives k beats on
// consecutive cycles; a tick with nothing due gives one beat with status none.
// The beats of a tick follow back to back, because every update of the sorted
// row shifts the whole row at once.
// A new command may be started in the cycle in which the last result of the
// previous one is shown.
// Reset empties the queue and idles the controller; there is no clearing pass.
module sorted_alarm_queue_core #(
  parameter int DEPTH = saq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_opcode,
  input  logic [saq_pkg::DAY_W-1:0]          in_event_day,
  input  logic [saq_pkg::MIN_W-1:0]          in_event_minute,
  input  logic [saq_pkg::MS_W-1:0]           in_event_ms,
  input  logic [saq_pkg::MSG_W-1:0]          in_message_id,
  input  logic [saq_pkg::KIND_W-1:0]         in_tag_kind,
  input  logic [saq_pkg::TAG_W-1:0]          in_tag_id,
  input  logic signed [saq_pkg::VOICE_W-1:0] in_voice_value,
  input  logic [saq_pkg::IDX_W-1:0]          in_entry_index,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic [saq_pkg::MSG_W-1:0]          out_fired_message,
  output logic [saq_pkg::KIND_W-1:0]         out_fired_tag_kind,
  output logic [saq_pkg::TAG_W-1:0]          out_fired_tag_id,
  output logic signed [saq_pkg::VOICE_W-1:0] out_fired_voice_value,
  output logic [saq_pkg::DAY_W-1:0]          out_fired_day,
  output logic [saq_pkg::MIN_W-1:0]          out_fired_minute,
  output logic [saq_pkg::LEFT_W-1:0]         out_entries_left,
  output logic                               out_last
);
  import saq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  saq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  saq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_opcode             (in_opcode),
    .in_event_day          (in_event_day),
    .in_event_minute       (in_event_minute),
    .in_event_ms           (in_event_ms),
    .in_message_id         (in_message_id),
    .in_tag_kind           (in_tag_kind),
    .in_tag_id             (in_tag_id),
    .in_voice_value        (in_voice_value),
    .in_entry_index        (in_entry_index),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_fired_message     (out_fired_message),
    .out_fired_tag_kind    (out_fired_tag_kind),
    .out_fired_tag_id      (out_fired_tag_id),
    .out_fired_voice_value (out_fired_voice_value),
    .out_fired_day         (out_fired_day),
    .out_fired_minute      (out_fired_minute),
    .out_entries_left      (out_entries_left),
    .out_last              (out_last)
  );

endmodule

// ----- bench/tb_sorted_alarm_queue_core.sv -----
module tb_sorted_alarm_queue_core;
  import saq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int RANDOM_CMDS = 370;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    op_t                 op;
    logic [DAY_W-1:0]    day;
    logic [MIN_W-1:0]    minute;
    logic [MS_W-1:0]     ms;
    logic [MSG_W-1:0]    message;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [VOICE_W-1:0]  voice;
    logic [IDX_W-1:0]    index;
    logic [7:0]          idle_before;
  } alarm_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [MSG_W-1:0]    message;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [VOICE_W-1:0]  voice;
    logic [DAY_W-1:0]    day;
    logic [MIN_W-1:0]    minute;
    logic [LEFT_W-1:0]   left;
    logic                last;
  } alarm_outcome_t;

  typedef struct packed {
    logic [MSG_W-1:0]    message;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
    logic [VOICE_W-1:0]  voice;
  } alarm_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  alarm_cmd_t cur_cmd = '0;

  logic                       out_valid;
  logic [2:0]                 out_status;
  logic [MSG_W-1:0]           out_fired_message;
  logic [KIND_W-1:0]          out_fired_tag_kind;
  logic [TAG_W-1:0]           out_fired_tag_id;
  logic signed [VOICE_W-1:0]  out_fired_voice_value;
  logic [DAY_W-1:0]           out_fired_day;
  logic [MIN_W-1:0]           out_fired_minute;
  logic [LEFT_W-1:0]          out_entries_left;
  logic                       out_last;

  sorted_alarm_queue_core #(.DEPTH(QDEPTH)) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (cur_cmd.op),
    .in_event_day          (cur_cmd.day),
    .in_event_minute       (cur_cmd.minute),
    .in_event_ms           (cur_cmd.ms),
    .in_message_id         (cur_cmd.message),
    .in_tag_kind           (cur_cmd.kind),
    .in_tag_id             (cur_cmd.tag),
    .in_voice_value        (cur_cmd.voice),
    .in_entry_index        (cur_cmd.index),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_fired_message     (out_fired_message),
    .out_fired_tag_kind    (out_fired_tag_kind),
    .out_fired_tag_id      (out_fired_tag_id),
    .out_fired_voice_value (out_fired_voice_value),
    .out_fired_day         (out_fired_day),
    .out_fired_minute      (out_fired_minute),
    .out_entries_left      (out_entries_left),
    .out_last              (out_last)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  alarm_cmd_t     pending_cmds[$];
  alarm_outcome_t awaited_results[$];

  // Shadow of the sorted alarm store.
  logic [KEY_W-1:0] shadow_key[QDEPTH];
  alarm_slot_t      shadow_slot[QDEPTH];
  int               shadow_count = 0;

  int   mismatches = 0;
  int   cmds_taken = 0;
  int   cmds_total = 0;
  int   fired_total = 0;
  int   full_hits = 0;
  int   bad_index_hits = 0;
  int   idle_ticks = 0;
  int   deepest_burst = 0;
  int   idle_count = 0;
  int   quiet_cycles = 0;
  int   calm_left = 0;
  logic beat_taken = 1'b0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH beat %0d: %s got %0h want %0h", fired_total, what, got, want);
  endtask

  function automatic logic [LEFT_W-1:0] left_of(int n);
    return (n > 31) ? LEFT_W'(31) : LEFT_W'(n);
  endfunction

  task automatic predict_outcomes(alarm_cmd_t c);
    logic [KEY_W-1:0] now_key;
    alarm_outcome_t   res;
    int               pos;
    int               i;
    int               n;
    now_key = {c.day, c.minute, c.ms};
    res = '0;
    res.last = 1'b1;
    case (c.op)
      OP_ADD: begin
        if (shadow_count >= QDEPTH) begin
          res.status = ST_FULL;
          full_hits++;
        end else begin
          // Equal keys go behind the ones already stored.
          pos = 0;
          while (pos < shadow_count && shadow_key[pos] <= now_key)
            pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_slot[i] = shadow_slot[i-1];
          end
          shadow_key[pos] = now_key;
          shadow_slot[pos] = '{c.message, c.kind, c.tag, c.voice};
          shadow_count++;
          res.status = ST_DONE;
        end
        res.left = left_of(shadow_count);
        awaited_results.push_back(res);
      end
      OP_REMOVE: begin
        if (int'(c.index) >= shadow_count) begin
          res.status = ST_BADIDX;
          bad_index_hits++;
        end else begin
          for (i = int'(c.index); i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_slot[i] = shadow_slot[i+1];
          end
          shadow_count--;
          res.status = ST_DONE;
        end
        res.left = left_of(shadow_count);
        awaited_results.push_back(res);
      end
      OP_CLEAR: begin
        shadow_count = 0;
        res.status = ST_DONE;
        res.left = 0;
        awaited_results.push_back(res);
      end
      default: begin
        n = 0;
        // A head fires on a matching minute of any day, or when strictly earlier.
        while (n < MAX_RESULTS && shadow_count > 0 &&
               (shadow_key[0][MS_W +: MIN_W] == c.minute || shadow_key[0] < now_key)) begin
          res = '0;
          res.status  = ST_FIRED;
          res.message = shadow_slot[0].message;
          res.kind    = shadow_slot[0].kind;
          res.tag     = shadow_slot[0].tag;
          res.voice   = shadow_slot[0].voice;
          res.day     = shadow_key[0][KEY_W-1 -: DAY_W];
          res.minute  = shadow_key[0][MS_W +: MIN_W];
          for (i = 0; i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_slot[i] = shadow_slot[i+1];
          end
          shadow_count--;
          res.left = left_of(shadow_count);
          res.last = 1'b0;
          awaited_results.push_back(res);
          n++;
        end
        if (n == 0) begin
          res = '0;
          res.status = ST_NONE;
          res.left = left_of(shadow_count);
          res.last = 1'b1;
          awaited_results.push_back(res);
          idle_ticks++;
        end else begin
          res = awaited_results.pop_back();
          res.last = 1'b1;
          awaited_results.push_back(res);
          fired_total += n;
          if (n > deepest_burst)
            deepest_burst = n;
        end
      end
    endcase
  endtask

  // Mostly back-to-back beats, some short gaps, a few long ones, and calm stretches.
  function automatic logic [7:0] pick_idle();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 8'd0;
    end
    r = $urandom_range(0, 99);
    if (r < 3)
      calm_left = $urandom_range(10, 30);
    if (r < 55)
      return 8'd0;
    if (r < 85)
      return 8'($urandom_range(1, 3));
    if (r < 97)
      return 8'($urandom_range(4, 12));
    return 8'($urandom_range(20, 60));
  endfunction

  task automatic queue_cmd(op_t op, logic [DAY_W-1:0] day, logic [MIN_W-1:0] minute,
                           logic [MS_W-1:0] ms, logic [MSG_W-1:0] message,
                           logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                           logic [VOICE_W-1:0] voice, logic [IDX_W-1:0] index);
    alarm_cmd_t c;
    c.op = op;
    c.day = day;
    c.minute = minute;
    c.ms = ms;
    c.message = message;
    c.kind = kind;
    c.tag = tag;
    c.voice = voice;
    c.index = index;
    c.idle_before = pick_idle();
    pending_cmds.push_back(c);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || beat_taken)) begin
      if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (idle_count < int'(pending_cmds[0].idle_before)) begin
        idle_count <= idle_count + 1;
        start <= 1'b0;
      end else begin
        cur_cmd <= pending_cmds.pop_front();
        start <= 1'b1;
        idle_count <= 0;
      end
    end
  end

  always @(posedge clk) begin
    alarm_outcome_t want;
    if (!rst_n) begin
      beat_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid !== 1'b0) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing awaited, status", out_status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_fired_message !== want.message)
            report_mismatch("fired_message", out_fired_message, want.message);
          if (out_fired_tag_kind !== want.kind)
            report_mismatch("fired_tag_kind", out_fired_tag_kind, want.kind);
          if (out_fired_tag_id !== want.tag)
            report_mismatch("fired_tag_id", out_fired_tag_id, want.tag);
          if (out_fired_voice_value !== want.voice)
            report_mismatch("fired_voice_value", out_fired_voice_value, want.voice);
          if (out_fired_day !== want.day)
            report_mismatch("fired_day", out_fired_day, want.day);
          if (out_fired_minute !== want.minute)
            report_mismatch("fired_minute", out_fired_minute, want.minute);
          if (out_entries_left !== want.left)
            report_mismatch("entries_left", out_entries_left, want.left);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      // The last result of one command and the next command beat may share an edge.
      if (start && !busy) begin
        predict_outcomes(cur_cmd);
        cmds_taken++;
      end
      beat_taken <= start && !busy;
      if (out_valid !== 1'b0 || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [DAY_W-1:0] clock_day;
    logic [MIN_W-1:0] clock_min;
    logic [MS_W-1:0]  ms_pick;
    int k;
    int r;
    int m;

    // Directed opening: empty store, a full store with extreme fields, errors, ticks.
    queue_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_cmd(OP_TICK, 16'hFFFF, 11'd1439, 16'd59999, 0, 0, 0, 0, 0);
    queue_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 8'd0);
    for (k = 0; k < QDEPTH; k++) begin
      case (k % 4)
        0: ms_pick = 16'd0;
        1: ms_pick = 16'd59999;
        2: ms_pick = 16'hFFFF;
        default: ms_pick = 16'd0;
      endcase
      queue_cmd(OP_ADD,
                (k == 3) ? 16'hFFFF : ((k == 5) ? 16'd0 : 16'd100),
                (k == 15) ? 11'h7FF : ((k < 8) ? 11'd600 : 11'd601),
                ms_pick,
                (k % 2) ? 16'hFFFF : 16'(k),
                2'(k),
                (k % 3 == 0) ? 8'hFF : 8'(k),
                (k % 2) ? 16'h8000 : 16'h7FFF,
                8'hFF);
    end
    queue_cmd(OP_ADD, 16'd50, 11'd10, 16'd10, 16'hABCD, 2'd3, 8'h5A, 16'h1234, 0);
    queue_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
    queue_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 8'd15);
    queue_cmd(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 8'd0);
    queue_cmd(OP_TICK, 16'd100, 11'd600, 16'd0, 0, 0, 0, 0, 0);
    queue_cmd(OP_TICK, 16'hFFFF, 11'h7FF, 16'hFFFF, 0, 0, 0, 0, 0);

    // Random part: a running wall clock, alarms set a few minutes ahead and
    // ticks that walk the clock forward, with some noise mixed in.
    clock_day = 16'($urandom_range(0, 65530));
    clock_min = 11'($urandom_range(0, 1439));
    for (k = 0; k < RANDOM_CMDS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        queue_cmd(op_t'($urandom_range(0, 3)), 16'($urandom), 11'($urandom_range(0, 2047)),
                  16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom),
                  16'($urandom), 8'($urandom));
      end else if (r < 55) begin
        m = (int'(clock_min) + $urandom_range(0, 4)) % 1440;
        ms_pick = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? 16'd0 : 16'd59999)
                                              : 16'($urandom_range(0, 59999));
        queue_cmd(OP_ADD, clock_day + 16'($urandom_range(0, 9) == 0), 11'(m), ms_pick,
                  16'($urandom), 2'($urandom), 8'($urandom), 16'($urandom),
                  8'($urandom));
      end else if (r < 85) begin
        m = int'(clock_min) + $urandom_range(0, 3);
        if (m >= 1440) begin
          m -= 1440;
          clock_day++;
        end
        clock_min = 11'(m);
        // An earlier day with the same minute still fires on the minute match.
        queue_cmd(OP_TICK, ($urandom_range(0, 9) == 0) ? clock_day - 16'd1 : clock_day,
                  clock_min, 16'($urandom_range(0, 59999)), 16'($urandom), 2'($urandom),
                  8'($urandom), 16'($urandom), 8'($urandom));
      end else if (r < 96) begin
        queue_cmd(OP_REMOVE, 16'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), 8'($urandom), 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 15)));
      end else begin
        queue_cmd(OP_CLEAR, 16'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                  2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    cmds_total = pending_cmds.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(cmds_taken == cmds_total && awaited_results.size() == 0))
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("ran %0d commands; %0d alarms fired, up to %0d on a single tick",
             cmds_taken, fired_total, deepest_burst);
    $display("%0d adds refused on a full store, %0d bad remove indexes, %0d ticks with nothing due",
             full_hits, bad_index_hits, idle_ticks);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
